/* hw/rtl/blhm_pkg.sv */
// Package for the battery level hysteresis monitor: field widths, register
// indexes, reset values, level codes, thresholds and the hysteresis quantizer.
// No dependencies.
package blhm_pkg;

  // Field and register widths
  localparam int MV_W        = 14;  // battery millivolts
  localparam int FRAC_BITS   = 8;   // filter fraction bits
  localparam int FILT_W      = MV_W + FRAC_BITS;
  localparam int EMA_NUM_W   = FILT_W + 3;  // raw*256 + 4*filt, below 5 * 2^22
  localparam int EMA_DIV_W   = 3;   // divisor 5
  localparam int SCALE_W     = 14;
  localparam int SCALE_SHIFT = 12;  // Q12 factor
  localparam int SPW_W       = 7;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_IDX_W   = 1;
  localparam int PCT_W       = 7;

  localparam logic [MV_W-1:0]      MV_MAX     = 14'd16383;
  localparam logic [EMA_DIV_W-1:0] EMA_DIVISOR = 3'd5;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_SCALE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_WINDOW = 1'b1;
  localparam logic [SCALE_W-1:0]   SCALE_RESET            = 14'd5195;
  localparam logic [SPW_W-1:0]     SPW_RESET              = 7'd32;

  // Charge level codes
  typedef enum logic [2:0] {
    LVL_0   = 3'd0,
    LVL_25  = 3'd1,
    LVL_50  = 3'd2,
    LVL_75  = 3'd3,
    LVL_100 = 3'd4
  } level_t;

  // Thresholds in mV with fraction bits appended
  localparam logic [FILT_W-1:0] TH_4150 = FILT_W'(4150 << FRAC_BITS);
  localparam logic [FILT_W-1:0] TH_4080 = FILT_W'(4080 << FRAC_BITS);
  localparam logic [FILT_W-1:0] TH_3980 = FILT_W'(3980 << FRAC_BITS);
  localparam logic [FILT_W-1:0] TH_3900 = FILT_W'(3900 << FRAC_BITS);
  localparam logic [FILT_W-1:0] TH_3840 = FILT_W'(3840 << FRAC_BITS);
  localparam logic [FILT_W-1:0] TH_3700 = FILT_W'(3700 << FRAC_BITS);
  localparam logic [FILT_W-1:0] TH_3500 = FILT_W'(3500 << FRAC_BITS);
  localparam logic [FILT_W-1:0] TH_3400 = FILT_W'(3400 << FRAC_BITS);

  // Hysteresis step: a rising and a falling threshold for each inner level
  function automatic level_t next_level(level_t code, logic [FILT_W-1:0] f);
    level_t nl;
    nl = code;
    case (code)
      LVL_100: nl = (f < TH_4080) ? LVL_75 : LVL_100;
      LVL_75: begin
        if (f >= TH_4150)     nl = LVL_100;
        else if (f < TH_3900) nl = LVL_50;
        else                  nl = LVL_75;
      end
      LVL_50: begin
        if (f >= TH_3980)     nl = LVL_75;
        else if (f < TH_3700) nl = LVL_25;
        else                  nl = LVL_50;
      end
      LVL_25: begin
        if (f >= TH_3840)     nl = LVL_50;
        else if (f < TH_3400) nl = LVL_0;
        else                  nl = LVL_25;
      end
      LVL_0: nl = (f >= TH_3500) ? LVL_25 : LVL_0;
      default: begin
        // corrupted code: pick by rising thresholds only
        if (f >= TH_4150)      nl = LVL_100;
        else if (f >= TH_3980) nl = LVL_75;
        else if (f >= TH_3840) nl = LVL_50;
        else if (f >= TH_3500) nl = LVL_25;
        else                   nl = LVL_0;
      end
    endcase
    return nl;
  endfunction

  // Level code to percent
  function automatic logic [PCT_W-1:0] pct_of(level_t code);
    logic [PCT_W-1:0] p;
    case (code)
      LVL_0:   p = 7'd0;
      LVL_25:  p = 7'd25;
      LVL_50:  p = 7'd50;
      LVL_75:  p = 7'd75;
      default: p = 7'd100;
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/blhm_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Needs the dividend's top D_W bits below the divisor. Depends on nothing.
module blhm_div #(
  parameter int Q_W = 12,
  parameter int D_W = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [Q_W+D_W-1:0] dividend,
  input  logic [D_W-1:0]     divisor,
  output logic               done,
  output logic [Q_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [Q_W-1:0]   qsh;
  logic [D_W:0]     trial;
  logic             ge;
  logic [D_W:0]     diff;

  // Trial subtract of the next dividend bit
  assign trial = {rem, qsh[Q_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  // Remainder and shared dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[Q_W+D_W-1:Q_W];
      qsh <= dividend[Q_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      qsh <= {qsh[Q_W-2:0], ge};
    end
  end

  assign quotient = qsh;

endmodule

/* hw/rtl/blhm_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on nothing.
module blhm_mul #(
  parameter int A_W = 12,
  parameter int B_W = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);

  localparam int CNT_W = $clog2(A_W + 1);
  localparam int P_W   = A_W + B_W;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [P_W-1:0]   prod;
  logic [B_W-1:0]   b_q;
  logic [B_W:0]     psum;

  // Add the multiplicand into the upper half when the low bit is set
  assign psum = prod[0] ? ({1'b0, prod[P_W-1:A_W]} + {1'b0, b_q})
                        : {1'b0, prod[P_W-1:A_W]};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(A_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  // Product shift register
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{B_W{1'b0}}, a};
      b_q  <= b;
    end else if (busy) begin
      prod <= {psum, prod[A_W-1:1]};
    end
  end

  assign product = prod;

endmodule

/* hw/rtl/battery_level_hysteresis_monitor.sv */
// Battery level monitor: each request carries one ADC sample in mV and
// returns one result. A request that does not close a window goes straight
// to the output state. A request that closes a window runs three bit-serial
// units in turn: the window average divider (SAMPLE_BITS steps), the Q12
// scale multiplier (SAMPLE_BITS steps) and the divide-by-five of the EMA
// (22 steps); the very first window skips the divide-by-five. One request
// is worked on at a time; a finished result sits in the output register
// while the next request enters.
// Depends on blhm_pkg, blhm_div and blhm_mul.
module battery_level_hysteresis_monitor
  import blhm_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_WINDOW  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // sample request
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample_mv,
  // result
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PCT_W-1:0]       level_percent,
  output logic [MV_W-1:0]        filtered_mv,
  output logic [MV_W-1:0]        raw_mv,
  output logic                   window_done
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int CMP_W  = (CNT_W > SPW_W) ? CNT_W : SPW_W;
  localparam int PROD_W = SAMPLE_BITS + SCALE_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_FILT  = 7'b0001000,
    S_EMA   = 7'b0010000,
    S_LEVEL = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [SCALE_W-1:0] divider_scale;
  logic [SPW_W-1:0]   samples_per_window;

  logic [SUM_W-1:0]  sample_sum;
  logic [CNT_W-1:0]  sample_count;
  logic [FILT_W-1:0] filter_value;
  logic              filter_primed;
  level_t            level_code;
  logic [MV_W-1:0]   raw_value;
  logic              closed;

  logic [SUM_W-1:0]     sum_next;
  logic [CNT_W-1:0]     count_next;
  logic [CMP_W-1:0]     win;
  logic                 accept;
  logic                 close_now;
  logic                 out_free;

  logic                   avg_done;
  logic [SAMPLE_BITS-1:0] avg;
  logic                   mul_done;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      scaled;
  logic                   ema_start;
  logic                   ema_done;
  logic [FILT_W-1:0]      ema_q;
  logic [EMA_NUM_W-1:0]   ema_num;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_scale      <= SCALE_RESET;
      samples_per_window <= SPW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DIVIDER_SCALE:      divider_scale      <= cfg_data[SCALE_W-1:0];
        CFG_SAMPLES_PER_WINDOW: samples_per_window <= cfg_data[SPW_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window: zero acts as one, clamp to MAX_WINDOW
  always_comb begin
    win = CMP_W'(samples_per_window);
    if (samples_per_window == '0) win = CMP_W'(1);
    else if (CMP_W'(samples_per_window) > CMP_W'(MAX_WINDOW)) win = CMP_W'(MAX_WINDOW);
  end

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign sum_next   = sample_sum + SUM_W'(sample_mv);
  assign count_next = sample_count + CNT_W'(1);
  assign close_now  = CMP_W'(count_next) >= win;
  assign out_free   = !out_valid || !out_stall;

  // Window average: sum / count
  blhm_div #(
    .Q_W (SAMPLE_BITS),
    .D_W (CNT_W)
  ) u_avg_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && close_now),
    .dividend (sum_next),
    .divisor  (count_next),
    .done     (avg_done),
    .quotient (avg)
  );

  // Scale to battery mV
  blhm_mul #(
    .A_W (SAMPLE_BITS),
    .B_W (SCALE_W)
  ) u_scale_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (avg_done),
    .a       (avg),
    .b       (divider_scale),
    .done    (mul_done),
    .product (prod)
  );

  assign scaled = prod >> SCALE_SHIFT;

  // EMA: (raw*256 + 4*filt) / 5
  assign ema_num   = EMA_NUM_W'({raw_value, {FRAC_BITS{1'b0}}})
                   + EMA_NUM_W'({filter_value, 2'b00});
  assign ema_start = (state == S_FILT) && filter_primed;

  blhm_div #(
    .Q_W (FILT_W),
    .D_W (EMA_DIV_W)
  ) u_ema_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ema_start),
    .dividend (ema_num),
    .divisor  (EMA_DIVISOR),
    .done     (ema_done),
    .quotient (ema_q)
  );

  // Sequencer and monitor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_sum    <= '0;
      sample_count  <= '0;
      filter_value  <= '0;
      filter_primed <= 1'b0;
      level_code    <= LVL_100;
      raw_value     <= '0;
      closed        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            closed <= close_now;
            if (close_now) begin
              sample_sum   <= '0;
              sample_count <= '0;
              state        <= S_DIV;
            end else begin
              sample_sum   <= sum_next;
              sample_count <= count_next;
              state        <= S_OUT;
            end
          end
        end
        S_DIV: begin
          if (avg_done) state <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            raw_value <= (scaled > PROD_W'(MV_MAX)) ? MV_MAX : scaled[MV_W-1:0];
            state     <= S_FILT;
          end
        end
        S_FILT: begin
          if (filter_primed) begin
            state <= S_EMA;
          end else begin
            // first window loads the filter directly
            filter_value  <= {raw_value, {FRAC_BITS{1'b0}}};
            filter_primed <= 1'b1;
            state         <= S_LEVEL;
          end
        end
        S_EMA: begin
          if (ema_done) begin
            filter_value <= ema_q;
            state        <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          level_code <= next_level(level_code, filter_value);
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      level_percent <= pct_of(level_code);
      filtered_mv   <= filter_value[FILT_W-1:FRAC_BITS];
      raw_mv        <= raw_value;
      window_done   <= closed;
    end
  end

  // Serial units only report back in the state that waits for them
  a_avg_done_state: assert property (@(posedge clk) disable iff (rst)
    avg_done |-> (state == S_DIV))
    else $error("average divider finished outside its state");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MUL))
    else $error("scale multiplier finished outside its state");

  a_ema_done_state: assert property (@(posedge clk) disable iff (rst)
    ema_done |-> (state == S_EMA))
    else $error("EMA divider finished outside its state");

  // Partial window never reaches the window limit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(sample_count) < CMP_W'(MAX_WINDOW))
    else $error("sample count reached the window limit");

  // A closed window always leaves the filter primed
  a_primed_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_done) |-> filter_primed)
    else $error("window result with unprimed filter");

endmodule

/* tb/gauge_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the battery level monitor: watches the config port and the
// request and result channels, predicts every result and compares it field by field.
// Depends on blhm_pkg.
module gauge_checker
  import blhm_pkg::*;
#(
  parameter int ADC_W   = 12,
  parameter int MAX_WIN = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [ADC_W-1:0]      sample_mv,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PCT_W-1:0]      level_percent,
  input  logic [MV_W-1:0]       filtered_mv,
  input  logic [MV_W-1:0]       raw_mv,
  input  logic                  window_done,
  output int unsigned           fail_count,
  output int unsigned           pending,
  output int unsigned           windows_closed
);

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic [MV_W-1:0]  filt_mv;
    logic [MV_W-1:0]  raw_mv;
    logic             done;
  } gauge_result_t;

  gauge_result_t expected_q[$];

  // Predictor copy of registers and state
  logic [SCALE_W-1:0]   scale_q12;
  logic [SPW_W-1:0]     window_len;
  logic [17:0]          acc_sum;
  logic [SPW_W-1:0]     acc_count;
  logic [FILT_W-1:0]    ema_q8;
  bit                   ema_loaded;
  level_t               charge;
  logic [MV_W-1:0]      last_raw_mv;

  // Threshold to climb one level, in mV
  function automatic int unsigned rise_mv(level_t c);
    case (c)
      LVL_0:   return 3500;
      LVL_25:  return 3840;
      LVL_50:  return 3980;
      default: return 4150;
    endcase
  endfunction

  // Threshold below which the level drops one step, in mV
  function automatic int unsigned fall_mv(level_t c);
    case (c)
      LVL_25:  return 3400;
      LVL_50:  return 3700;
      LVL_75:  return 3900;
      default: return 4080;
    endcase
  endfunction

  // Hysteresis: rising check has priority over falling
  function automatic level_t step_level(level_t c, logic [FILT_W-1:0] f);
    if (c != LVL_100 && f >= (rise_mv(c) << FRAC_BITS)) return level_t'(c + 1);
    if (c != LVL_0 && f < (fall_mv(c) << FRAC_BITS)) return level_t'(c - 1);
    return c;
  endfunction

  // Accumulate one sample and queue the result it produces
  task automatic predict_sample(input logic [ADC_W-1:0] s);
    int unsigned         win;
    logic [ADC_W-1:0]    avg;
    logic [31:0]         scaled;
    logic [FILT_W+2:0]   ema_num;
    gauge_result_t       r;
    win = window_len;
    if (win < 1) win = 1;
    if (win > MAX_WIN) win = MAX_WIN;
    acc_sum = acc_sum + s;
    acc_count = acc_count + 1'b1;
    r.done = 1'b0;
    if (acc_count >= win) begin
      // average over the samples actually summed, then Q12 scale
      avg = ADC_W'(acc_sum / acc_count);
      scaled = (32'(avg) * 32'(scale_q12)) >> SCALE_SHIFT;
      last_raw_mv = (scaled > 32'(MV_MAX)) ? MV_MAX : scaled[MV_W-1:0];
      // first window loads the filter, later ones blend 1/5 in
      if (!ema_loaded) begin
        ema_q8 = {last_raw_mv, {FRAC_BITS{1'b0}}};
        ema_loaded = 1'b1;
      end else begin
        ema_num = ((FILT_W+3)'(last_raw_mv) << FRAC_BITS) + (FILT_W+3)'(ema_q8) * 4;
        ema_q8 = FILT_W'(ema_num / 5);
      end
      charge = step_level(charge, ema_q8);
      acc_sum = '0;
      acc_count = '0;
      r.done = 1'b1;
      windows_closed++;
    end
    r.pct = PCT_W'(25 * int'(charge));
    r.filt_mv = ema_q8[FILT_W-1:FRAC_BITS];
    r.raw_mv = last_raw_mv;
    expected_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [MV_W-1:0] want,
                             input logic [MV_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    gauge_result_t e;
    if (expected_q.size() == 0) begin
      $error("result arrived with no request outstanding");
      fail_count++;
    end else begin
      e = expected_q.pop_front();
      check_field("level_percent", MV_W'(e.pct), MV_W'(level_percent));
      check_field("filtered_mv", e.filt_mv, filtered_mv);
      check_field("raw_mv", e.raw_mv, raw_mv);
      check_field("window_done", MV_W'(e.done), MV_W'(window_done));
    end
  endtask

  // Channel monitor: results are checked before the same-edge request is queued
  always @(posedge clk) begin
    if (rst) begin
      scale_q12 = SCALE_RESET;
      window_len = SPW_RESET;
      acc_sum = '0;
      acc_count = '0;
      ema_q8 = '0;
      ema_loaded = 1'b0;
      charge = LVL_100;
      last_raw_mv = '0;
      expected_q.delete();
      fail_count = 0;
      windows_closed = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_sample(sample_mv);
      if (cfg_write) begin
        if (cfg_index == CFG_DIVIDER_SCALE) scale_q12 = cfg_data[SCALE_W-1:0];
        else if (cfg_index == CFG_SAMPLES_PER_WINDOW) window_len = cfg_data[SPW_W-1:0];
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Top of the battery level monitor testbench: clock, reset, config writes,
// sample stimulus and verdict. Depends on blhm_pkg, gauge_checker and the RTL.
module tb_top
  import blhm_pkg::*;
();

  localparam int ADC_W        = 12;
  localparam int N_RANDOM     = 1150;
  localparam int DRAIN_CYCLES = 100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic [ADC_W-1:0]      sample_mv = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [PCT_W-1:0]      level_percent;
  logic [MV_W-1:0]       filtered_mv;
  logic [MV_W-1:0]       raw_mv;
  logic                  window_done;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned windows_closed;
  int unsigned samples_sent = 0;
  int unsigned reg_writes = 0;
  bit          quiet = 1'b0;
  logic [SCALE_W-1:0] cur_scale = SCALE_RESET;

  battery_level_hysteresis_monitor i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample_mv(sample_mv),
    .out_valid(out_valid), .out_stall(out_stall),
    .level_percent(level_percent), .filtered_mv(filtered_mv),
    .raw_mv(raw_mv), .window_done(window_done)
  );

  gauge_checker #(.ADC_W(ADC_W)) i_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample_mv(sample_mv),
    .out_valid(out_valid), .out_stall(out_stall),
    .level_percent(level_percent), .filtered_mv(filtered_mv),
    .raw_mv(raw_mv), .window_done(window_done),
    .fail_count(fail_count), .pending(pending), .windows_closed(windows_closed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit: far above the slowest legal run
  initial begin
    #5000000;
    $display("battery_level_hysteresis_monitor: mismatch");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 8);
  end

  // One sample request, with random idle cycles ahead of it unless quiet
  task automatic send_sample(input logic [ADC_W-1:0] v);
    if (!quiet) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    sample_mv <= v;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // Block must be drained before a register write
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DIVIDER_SCALE) cur_scale = SCALE_W'(val);
    reg_writes++;
  endtask

  // ADC code that maps to a battery voltage under the current scale
  function automatic logic [ADC_W-1:0] adc_for_mv(int mv);
    int code;
    if (cur_scale == 0) return ADC_W'($urandom_range(4095));
    code = (mv * 4096) / int'(cur_scale);
    if (code < 0) code = 0;
    if (code > 4095) code = 4095;
    return ADC_W'(code);
  endfunction

  initial begin
    int unsigned random_done;
    int unsigned pick;
    int unsigned phase_len;
    int          batt_mv;
    int          dir;
    bit          ramp;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Before the first window: results hold zero voltages and 100 percent
    send_sample(12'd1234);
    send_sample(12'd4095);
    send_sample(12'd0);

    // One-sample windows at full scale: filter load, then blending
    write_reg(CFG_SAMPLES_PER_WINDOW, 1);
    write_reg(CFG_DIVIDER_SCALE, 16383);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'hAAA);
    send_sample(12'h555);

    // Zero scale drives the raw voltage to zero
    write_reg(CFG_DIVIDER_SCALE, 0);
    send_sample(12'd2000);

    // Window length zero acts as one
    write_reg(CFG_SAMPLES_PER_WINDOW, 0);
    write_reg(CFG_DIVIDER_SCALE, 5195);
    send_sample(12'd3300);
    send_sample(12'd3300);

    // Window shrunk while partly filled: closes on the next sample
    write_reg(CFG_SAMPLES_PER_WINDOW, 8);
    send_sample(12'd3000);
    send_sample(12'd3100);
    send_sample(12'd3200);
    write_reg(CFG_SAMPLES_PER_WINDOW, 2);
    send_sample(12'd2900);
    send_sample(12'd2800);
    send_sample(12'd2700);

    // Random phases: mostly slow voltage ramps through the thresholds,
    // some full-range noise with odd scales
    random_done = 0;
    batt_mv = 4200;
    dir = -1;
    while (random_done < N_RANDOM) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        case ($urandom_range(4))
          0:       write_reg(CFG_SAMPLES_PER_WINDOW, 0);
          1:       write_reg(CFG_SAMPLES_PER_WINDOW, 1);
          2:       write_reg(CFG_SAMPLES_PER_WINDOW, 64);
          3:       write_reg(CFG_SAMPLES_PER_WINDOW, 65);
          default: write_reg(CFG_SAMPLES_PER_WINDOW, 127);
        endcase
      end else if (pick < 85) begin
        write_reg(CFG_SAMPLES_PER_WINDOW, $urandom_range(8, 1));
      end else begin
        write_reg(CFG_SAMPLES_PER_WINDOW, $urandom_range(127, 9));
      end

      ramp = ($urandom_range(99) < 75);
      if (ramp) begin
        if ($urandom_range(1)) write_reg(CFG_DIVIDER_SCALE, $urandom_range(5600, 4800));
      end else begin
        case ($urandom_range(3))
          0:       write_reg(CFG_DIVIDER_SCALE, 0);
          1:       write_reg(CFG_DIVIDER_SCALE, 16383);
          default: write_reg(CFG_DIVIDER_SCALE, $urandom_range(16383));
        endcase
      end

      quiet = (random_done >= 450 && random_done < 650);
      phase_len = $urandom_range(80, 20);
      repeat (phase_len) begin
        if (ramp) begin
          if ($urandom_range(15) == 0) dir = -dir;
          batt_mv = batt_mv + dir * int'($urandom_range(25));
          if (batt_mv > 4500) dir = -1;
          if (batt_mv < 2900) dir = 1;
          send_sample(adc_for_mv(batt_mv + int'($urandom_range(80)) - 40));
        end else begin
          send_sample(ADC_W'($urandom_range(4095)));
        end
        random_done++;
      end
    end
    quiet = 1'b0;

    // Drain and let the block settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d closed windows, %0d register writes.",
             samples_sent, windows_closed, reg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("battery_level_hysteresis_monitor: match");
    end else begin
      $display("battery_level_hysteresis_monitor: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/blhm_pkg.sv
hw/rtl/blhm_div.sv
hw/rtl/blhm_mul.sv
hw/rtl/battery_level_hysteresis_monitor.sv
tb/gauge_checker.sv
tb/tb_top.sv
